FILE: sv/ahrc_pkg.sv
// ----------------------------------------------------------------------------
// ahrc_pkg
// Shared types, constants and the arctangent table for the arc ray crossing
// unit.
// ----------------------------------------------------------------------------
package ahrc_pkg;

  localparam int NLANE  = 2;   // crossing at center minus root, then plus root
  localparam int CW     = 36;  // CORDIC x/y width
  localparam int ZW     = 32;  // angle width, Q5.27
  localparam int SQ_W   = 62;  // radius squared minus offset squared
  localparam int RT_W   = 31;  // square root width
  localparam int DVD_W  = 58;  // scaled dividend width
  localparam int QT_W   = 34;  // quotient bits produced by the divider
  localparam int REM_W  = 30;  // divider remainder width, same as the sweep
  localparam int TAB_LEN = 30;

  localparam logic signed [ZW-1:0] HALF_PI = 32'sd210828714;
  localparam logic signed [32:0]   TWO_PI  = 33'sd843314856;
  localparam logic signed [32:0]   ANG_TOL = 33'sd13422;
  localparam logic signed [31:0]   U_ONE   = 32'sd16777216;
  localparam logic signed [31:0]   U_TOL   = 32'sd1678;
  localparam logic [29:0]          SWEEP_RESET = 30'd843314856;

  localparam logic [2:0] REG_CENTER_X    = 3'd0;
  localparam logic [2:0] REG_CENTER_Y    = 3'd1;
  localparam logic [2:0] REG_RADIUS      = 3'd2;
  localparam logic [2:0] REG_START_ANGLE = 3'd3;
  localparam logic [2:0] REG_SWEEP_ANGLE = 3'd4;

  typedef struct packed {
    logic               skip;
    logic signed [31:0] px;
    logic signed [32:0] dy;
  } sqrt_side_t;

  typedef struct packed {
    logic [NLANE-1:0]        take;
    logic                    zero;
    logic [NLANE-1:0][31:0]  xc;
  } cord_side_t;

  typedef struct packed {
    logic [NLANE-1:0]        take;
    logic [NLANE-1:0][31:0]  xc;
    logic [NLANE-1:0]        neg;
    logic [NLANE-1:0]        nz;
    logic [NLANE-1:0]        ovf;
  } div_side_t;

  // atan(2^-i) in Q5.27, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_entry(input int unsigned idx);
    unique case (idx)
      0:  atan_entry = 32'sd105414357;
      1:  atan_entry = 32'sd62229729;
      2:  atan_entry = 32'sd32880480;
      3:  atan_entry = 32'sd16690645;
      4:  atan_entry = 32'sd8377711;
      5:  atan_entry = 32'sd4192939;
      6:  atan_entry = 32'sd2096981;
      7:  atan_entry = 32'sd1048555;
      8:  atan_entry = 32'sd524285;
      9:  atan_entry = 32'sd262144;
      10: atan_entry = 32'sd131072;
      11: atan_entry = 32'sd65536;
      12: atan_entry = 32'sd32768;
      13: atan_entry = 32'sd16384;
      14: atan_entry = 32'sd8192;
      15: atan_entry = 32'sd4096;
      16: atan_entry = 32'sd2048;
      17: atan_entry = 32'sd1024;
      18: atan_entry = 32'sd512;
      19: atan_entry = 32'sd256;
      20: atan_entry = 32'sd128;
      21: atan_entry = 32'sd64;
      22: atan_entry = 32'sd32;
      23: atan_entry = 32'sd16;
      24: atan_entry = 32'sd8;
      25: atan_entry = 32'sd4;
      26: atan_entry = 32'sd2;
      27: atan_entry = 32'sd1;
      28: atan_entry = 32'sd1;
      default: atan_entry = '0;
    endcase
  endfunction

endpackage

FILE: sv/arc_horizontal_ray_crossings_unit.sv
// ----------------------------------------------------------------------------
// arc_horizontal_ray_crossings_unit
// Crossings of a leftward horizontal ray with a configured circular arc.
// ----------------------------------------------------------------------------
// A query point is taken on every clock in which the output side is not
// holding a result. The pipeline is made of a 31-stage square root, one
// stage per CORDIC micro-rotation and a 34-stage divider, plus eight stages
// of offset, multiply, pre-rotation, angle wrap, scaling and output
// buffering. The output emits one beat per clock while out_ready is high,
// so a point with two crossings occupies the output for both beats and can
// hold the input while its first beat is sent; points with zero or one
// crossing flow at one per clock while out_ready is high.
// Configuration must be written only while the pipeline is empty.
//
// For each point the vertical offset to the circle center is compared with
// the radius; beyond it there is no crossing. Otherwise the root
// floor(sqrt(r^2 - dy^2)) gives the crossings center_x - root (lane 0) and
// center_x + root (lane 1), each emitted only if it lies strictly left of the
// point, lane 0 first. The last flag marks the final beat of a point.
// For each crossing the angle atan2(dy, +-root) is found by CORDIC, wrapped up
// by two pi when it falls below the start angle minus a small tolerance, and
// divided by the sweep into a Q8.24 arc parameter that is rounded, saturated
// and snapped to 0 or 1 when within 0.0001 of either.
module arc_horizontal_ray_crossings_unit
  import ahrc_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // query points
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  // crossings
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] cross_x,
  output logic signed [31:0] arc_param,
  output logic               right_side,
  output logic               last
);

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) begin
      sat34 = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      sat34 = 32'sh8000_0000;
    end else begin
      sat34 = v[31:0];
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic [30:0]        radius;
  logic [29:0]        start_angle;
  logic [29:0]        sweep_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      radius      <= '0;
      start_angle <= '0;
      sweep_angle <= SWEEP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CENTER_X:    center_x    <= cfg_data;
        REG_CENTER_Y:    center_y    <= cfg_data;
        REG_RADIUS:      radius      <= cfg_data[30:0];
        REG_START_ANGLE: start_angle <= cfg_data[29:0];
        REG_SWEEP_ANGLE: sweep_angle <= cfg_data[29:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; adv is its single advance enable.
  logic adv;
  assign in_ready = adv;

  // --------------------------------------------------------------------------
  // Stage 0: input register.
  // --------------------------------------------------------------------------
  logic               v0;
  logic signed [31:0] px0, py0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px0 <= point_x;
      py0 <= point_y;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: vertical offset and its magnitude against the radius.
  // --------------------------------------------------------------------------
  logic signed [32:0] dy_c;
  logic [32:0]        ady_c;
  logic               v1, skip1;
  logic signed [32:0] dy1;
  logic signed [31:0] px1;
  logic [30:0]        ady1;

  assign dy_c  = 33'(py0) - 33'(center_y);
  assign ady_c = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dy1   <= dy_c;
      px1   <= px0;
      skip1 <= ady_c > {2'b00, radius};
      ady1  <= ady_c[30:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: squares. Stage 3: r^2 - dy^2.
  // --------------------------------------------------------------------------
  logic [SQ_W-1:0]    sq_a_c, sq_r_c;
  logic               v2, skip2;
  logic signed [32:0] dy2;
  logic signed [31:0] px2;
  logic [SQ_W-1:0]    sq_a2, sq_r2;

  assign sq_a_c = ady1 * ady1;
  assign sq_r_c = radius * radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dy2   <= dy1;
      px2   <= px1;
      skip2 <= skip1;
      sq_a2 <= sq_a_c;
      sq_r2 <= sq_r_c;
    end
  end

  logic            v3;
  sqrt_side_t      side3;
  logic [SQ_W-1:0] rad3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side3.skip <= skip2;
      side3.px   <= px2;
      side3.dy   <= dy2;
      rad3       <= sq_r2 - sq_a2;
    end
  end

  // --------------------------------------------------------------------------
  // Square root.
  // --------------------------------------------------------------------------
  logic            sq_valid;
  logic [RT_W-1:0] root;
  sqrt_side_t      sq_side;

  ahrc_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v3),
    .value     (rad3),
    .side_in   (side3),
    .out_valid (sq_valid),
    .root      (root),
    .side_out  (sq_side)
  );

  // --------------------------------------------------------------------------
  // Stage 4: crossing positions and CORDIC pre-rotation.
  // Lane 0 works on the vector (-root, dy); when it points into the left half
  // plane it is turned by a quarter turn so that CORDIC starts with x >= 0.
  // --------------------------------------------------------------------------
  logic                 v4;
  cord_side_t           side4, side4_c;
  logic signed [CW-1:0] x4 [NLANE], x4_c [NLANE];
  logic signed [CW-1:0] y4 [NLANE], y4_c [NLANE];
  logic signed [ZW-1:0] z4 [NLANE], z4_c [NLANE];

  always_comb begin
    logic signed [CW-1:0] dyw, rtw;
    logic signed [33:0]   cxe, pxe, rte, xs0, xs1;
    dyw = CW'(sq_side.dy);
    rtw = CW'(root);
    cxe = 34'(center_x);
    pxe = 34'(sq_side.px);
    rte = 34'(root);
    xs0 = cxe - rte;
    xs1 = cxe + rte;

    side4_c.take[0] = !sq_side.skip && (xs0 < pxe);
    side4_c.take[1] = !sq_side.skip && (xs1 < pxe);
    side4_c.zero    = (root == '0) && (sq_side.dy == '0);
    side4_c.xc[0]   = sat34(xs0);
    side4_c.xc[1]   = sat34(xs1);

    if (root == '0) begin
      x4_c[0] = '0;
      y4_c[0] = dyw;
      z4_c[0] = '0;
    end else if (sq_side.dy >= 0) begin
      x4_c[0] = dyw;
      y4_c[0] = rtw;
      z4_c[0] = HALF_PI;
    end else begin
      x4_c[0] = -dyw;
      y4_c[0] = -rtw;
      z4_c[0] = -HALF_PI;
    end

    x4_c[1] = rtw;
    y4_c[1] = dyw;
    z4_c[1] = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side4 <= side4_c;
      x4    <= x4_c;
      y4    <= y4_c;
      z4    <= z4_c;
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC arctangent for both lanes.
  // --------------------------------------------------------------------------
  logic                 cd_valid;
  logic signed [ZW-1:0] cd_z [NLANE];
  cord_side_t           cd_side;

  ahrc_cordic_pipe #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v4),
    .x_in      (x4),
    .y_in      (y4),
    .z_in      (z4),
    .side_in   (side4),
    .out_valid (cd_valid),
    .z_out     (cd_z),
    .side_out  (cd_side)
  );

  // --------------------------------------------------------------------------
  // Stage 5: wrap the angle past the start and take the offset from it.
  // --------------------------------------------------------------------------
  logic signed [31:0] st_c;
  logic               v5;
  logic [NLANE-1:0]   take5, neg5, nz5, neg5_c, nz5_c;
  logic [NLANE-1:0][31:0] xc5;
  logic [32:0]        mag5 [NLANE], mag5_c [NLANE];

  assign st_c = 32'($signed(start_angle));

  always_comb begin
    logic signed [32:0] ang, lim, angw;
    logic signed [33:0] num;
    lim = 33'(st_c) - ANG_TOL;
    for (int l = 0; l < NLANE; l++) begin
      ang  = cd_side.zero ? 33'sd0 : 33'(cd_z[l]);
      angw = (ang < lim) ? ang + TWO_PI : ang;
      num  = 34'(angw) - 34'(st_c);
      neg5_c[l] = num[33];
      nz5_c[l]  = num != '0;
      mag5_c[l] = num[33] ? 33'(-num) : num[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= cd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      take5 <= cd_side.take;
      xc5   <= cd_side.xc;
      neg5  <= neg5_c;
      nz5   <= nz5_c;
      mag5  <= mag5_c;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: scale to Q8.24 with half the sweep added for rounding, and flag
  // quotients too large for the divider.
  // --------------------------------------------------------------------------
  logic             v6;
  div_side_t        side6, side6_c;
  logic [DVD_W-1:0] dvd6 [NLANE], dvd6_c [NLANE];

  always_comb begin
    side6_c.take = take5;
    side6_c.xc   = xc5;
    side6_c.neg  = neg5;
    side6_c.nz   = nz5;
    for (int l = 0; l < NLANE; l++) begin
      dvd6_c[l] = DVD_W'({mag5[l], 24'd0}) + DVD_W'(sweep_angle[29:1]);
      side6_c.ovf[l] = {6'd0, dvd6_c[l][DVD_W-1:QT_W]} >= sweep_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side6 <= side6_c;
      dvd6  <= dvd6_c;
    end
  end

  // --------------------------------------------------------------------------
  // Divider by the sweep.
  // --------------------------------------------------------------------------
  logic            dv_valid;
  logic [QT_W-1:0] dv_q [NLANE];
  div_side_t       dv_side;

  ahrc_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v6),
    .dvd       (dvd6),
    .den       (sweep_angle),
    .side_in   (side6),
    .out_valid (dv_valid),
    .quot      (dv_q),
    .side_out  (dv_side)
  );

  // --------------------------------------------------------------------------
  // Final arc parameter: sign, saturation, zero sweep and snapping.
  // --------------------------------------------------------------------------
  logic signed [31:0] u_c [NLANE];

  always_comb begin
    logic [32:0]        qs;
    logic signed [31:0] uv;
    for (int l = 0; l < NLANE; l++) begin
      if (dv_side.ovf[l] || dv_q[l] > 34'h1_0000_0000) begin
        qs = 33'h1_0000_0000;
      end else begin
        qs = dv_q[l][32:0];
      end
      if (dv_side.neg[l]) begin
        uv = (qs > 33'h0_8000_0000) ? 32'sh8000_0000 : 32'(32'd0 - qs[31:0]);
      end else begin
        uv = (qs > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(qs[31:0]);
      end
      if (sweep_angle == '0) begin
        if (!dv_side.nz[l]) begin
          uv = '0;
        end else begin
          uv = dv_side.neg[l] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
      end
      if (uv > -U_TOL && uv < U_TOL) begin
        uv = '0;
      end
      if (uv > U_ONE - U_TOL && uv < U_ONE + U_TOL) begin
        uv = U_ONE;
      end
      u_c[l] = uv;
    end
  end

  // --------------------------------------------------------------------------
  // Output buffer. It holds the crossings of one point and sends them one
  // beat at a time, lane 0 first. The pipeline advances when the buffer can
  // take the next point or the pipeline end holds a bubble.
  // --------------------------------------------------------------------------
  logic [NLANE-1:0]        pend;
  logic [NLANE-1:0][31:0]  ob_xc;
  logic signed [31:0]      ob_u [NLANE];
  logic                    sel, take_beat, can_load;

  assign sel       = ~pend[0];
  assign out_valid = |pend;
  assign last      = sel | ~pend[1];
  assign take_beat = out_valid & out_ready;
  assign can_load  = (pend == '0) | (take_beat & last);
  assign adv       = can_load | ~dv_valid;

  assign cross_x    = ob_xc[sel];
  assign arc_param  = ob_u[sel];
  assign right_side = sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (can_load) begin
      pend <= dv_valid ? dv_side.take : '0;
    end else if (take_beat) begin
      pend[sel] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      ob_xc <= dv_side.xc;
      ob_u  <= u_c;
    end
  end

endmodule

FILE: sv/ahrc_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// ahrc_sqrt_pipe
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ahrc_sqrt_pipe
  import ahrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   value,
  input  sqrt_side_t        side_in,
  output logic              out_valid,
  output logic [RT_W-1:0]   root,
  output sqrt_side_t        side_out
);

  logic              vq   [RT_W];
  sqrt_side_t        sq   [RT_W];
  logic [SQ_W-1:0]   remq [RT_W];
  logic [RT_W-1:0]   rtq  [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_step
    localparam int B = RT_W - 1 - k;
    logic            vi;
    sqrt_side_t      si;
    logic [SQ_W-1:0] ri;
    logic [RT_W-1:0] oi;
    logic [SQ_W-1:0] trial;

    if (k == 0) begin : g_head
      assign vi = in_valid;
      assign si = side_in;
      assign ri = value;
      assign oi = '0;
    end else begin : g_tail
      assign vi = vq[k-1];
      assign si = sq[k-1];
      assign ri = remq[k-1];
      assign oi = rtq[k-1];
    end

    // (root + 2^B)^2 - root^2, with root holding only bits above B.
    assign trial = (SQ_W'(oi) << (B + 1)) | (SQ_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[k] <= 1'b0;
      end else if (en) begin
        vq[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq[k] <= si;
        if (ri >= trial) begin
          remq[k]   <= ri - trial;
          rtq[k]    <= oi | (RT_W'(1) << B);
        end else begin
          remq[k]   <= ri;
          rtq[k]    <= oi;
        end
      end
    end
  end

  assign out_valid = vq[RT_W-1];
  assign root      = rtq[RT_W-1];
  assign side_out  = sq[RT_W-1];

endmodule

FILE: sv/ahrc_cordic_pipe.sv
// ----------------------------------------------------------------------------
// ahrc_cordic_pipe
// Vectoring CORDIC, one micro-rotation per stage, both crossings side by side.
// ----------------------------------------------------------------------------
module ahrc_cordic_pipe
  import ahrc_pkg::*;
#(
  parameter int STEPS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] x_in [NLANE],
  input  logic signed [CW-1:0] y_in [NLANE],
  input  logic signed [ZW-1:0] z_in [NLANE],
  input  cord_side_t           side_in,
  output logic                 out_valid,
  output logic signed [ZW-1:0] z_out [NLANE],
  output cord_side_t           side_out
);

  logic                 vq [STEPS];
  cord_side_t           sq [STEPS];
  logic signed [CW-1:0] xq [STEPS][NLANE];
  logic signed [CW-1:0] yq [STEPS][NLANE];
  logic signed [ZW-1:0] zq [STEPS][NLANE];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic                 vi;
    cord_side_t           si;
    logic signed [CW-1:0] xi [NLANE];
    logic signed [CW-1:0] yi [NLANE];
    logic signed [ZW-1:0] zi [NLANE];

    if (k == 0) begin : g_head
      assign vi = in_valid;
      assign si = side_in;
      assign xi = x_in;
      assign yi = y_in;
      assign zi = z_in;
    end else begin : g_tail
      assign vi = vq[k-1];
      assign si = sq[k-1];
      assign xi = xq[k-1];
      assign yi = yq[k-1];
      assign zi = zq[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[k] <= 1'b0;
      end else if (en) begin
        vq[k] <= vi;
      end
    end

    // Rotate toward the x axis; the sign of y picks the direction.
    always_ff @(posedge clk) begin
      if (en) begin
        sq[k] <= si;
        for (int l = 0; l < NLANE; l++) begin
          if (yi[l] >= 0) begin
            xq[k][l] <= xi[l] + (yi[l] >>> k);
            yq[k][l] <= yi[l] - (xi[l] >>> k);
            zq[k][l] <= zi[l] + atan_entry(k);
          end else begin
            xq[k][l] <= xi[l] - (yi[l] >>> k);
            yq[k][l] <= yi[l] + (xi[l] >>> k);
            zq[k][l] <= zi[l] - atan_entry(k);
          end
        end
      end
    end
  end

  assign out_valid = vq[STEPS-1];
  assign z_out     = zq[STEPS-1];
  assign side_out  = sq[STEPS-1];

endmodule

FILE: sv/ahrc_div_pipe.sv
// ----------------------------------------------------------------------------
// ahrc_div_pipe
// Pipelined restoring divider by the arc sweep, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ahrc_div_pipe
  import ahrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DVD_W-1:0] dvd [NLANE],
  input  logic [REM_W-1:0] den,
  input  div_side_t        side_in,
  output logic             out_valid,
  output logic [QT_W-1:0]  quot [NLANE],
  output div_side_t        side_out
);

  logic             vq  [QT_W];
  div_side_t        sq  [QT_W];
  logic [REM_W-1:0] rq  [QT_W][NLANE];
  logic [QT_W-1:0]  lq  [QT_W][NLANE];
  logic [QT_W-1:0]  qq  [QT_W][NLANE];

  for (genvar k = 0; k < QT_W; k++) begin : g_step
    localparam int B = QT_W - 1 - k;
    logic             vi;
    div_side_t        si;
    logic [REM_W-1:0] ri [NLANE];
    logic [QT_W-1:0]  li [NLANE];
    logic [QT_W-1:0]  qi [NLANE];

    if (k == 0) begin : g_head
      assign vi = in_valid;
      assign si = side_in;
      for (genvar l = 0; l < NLANE; l++) begin : g_lane
        // The high part is below the divisor unless the item overflows.
        assign ri[l] = REM_W'(dvd[l][DVD_W-1:QT_W]);
        assign li[l] = dvd[l][QT_W-1:0];
        assign qi[l] = '0;
      end
    end else begin : g_tail
      assign vi = vq[k-1];
      assign si = sq[k-1];
      assign ri = rq[k-1];
      assign li = lq[k-1];
      assign qi = qq[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[k] <= 1'b0;
      end else if (en) begin
        vq[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      logic [REM_W:0] t;
      if (en) begin
        sq[k] <= si;
        for (int l = 0; l < NLANE; l++) begin
          t = {ri[l], li[l][B]};
          lq[k][l] <= li[l];
          if (t >= {1'b0, den}) begin
            rq[k][l]    <= REM_W'(t - {1'b0, den});
            qq[k][l]    <= qi[l] | (QT_W'(1) << B);
          end else begin
            rq[k][l]    <= t[REM_W-1:0];
            qq[k][l]    <= qi[l];
          end
        end
      end
    end
  end

  assign out_valid = vq[QT_W-1];
  assign quot      = qq[QT_W-1];
  assign side_out  = sq[QT_W-1];

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the arc ray crossing unit.
// ----------------------------------------------------------------------------
// Query points are queued by a stimulus process and driven by a clocked
// driver with random idle bursts; crossings are collected by a clocked monitor
// under random back-pressure. Every accepted point is run through a bit-exact
// predictor (root, CORDIC angle, wrap, divide, snap) whose crossings are
// queued and compared field by field against the beats that leave the block.
// The run steps through several circle and arc settings, extremes included.
// ----------------------------------------------------------------------------
module tb_top
  import ahrc_pkg::*;
();

  localparam int STEPS     = 24;
  localparam int DRAIN_CYC = 130;  // pipeline depth plus margin

  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] u;
    logic               side;
    logic               fin;
  } crossing_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = REG_CENTER_X;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] cross_x;
  logic signed [31:0] arc_param;
  logic               right_side;
  logic               last;

  arc_horizontal_ray_crossings_unit #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .point_x, .point_y,
    .out_valid, .out_ready, .cross_x, .arc_param, .right_side, .last
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mirror of the configuration registers as the block holds them.
  logic [31:0] m_cx, m_cy;
  logic [30:0] m_r;
  logic [29:0] m_st, m_sw;

  logic signed [63:0] atan_q27 [STEPS];
  logic [63:0]        pending_pts[$];   // {point_y, point_x}
  crossing_t          crossings_due[$];

  int  errors = 0;
  int  beats_seen = 0;
  int  points_sent = 0;
  int  side_hits[2] = '{0, 0};
  bit  calm = 1'b0;          // no idling on either side
  bit  pt_taken = 1'b0;
  int  in_gap = 0;
  int  out_stall = 0;

  // arctan(1/n) in Q60 by its alternating series.
  function automatic longint unsigned atan_recip(longint unsigned n);
    longint unsigned t, acc, n2, k;
    t = (64'd1 << 60) / n;
    acc = 0;
    n2 = n * n;
    k = 0;
    while (t != 0) begin
      if (k[0]) acc -= t / (2 * k + 1);
      else acc += t / (2 * k + 1);
      t /= n2;
      k++;
    end
    return acc;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC; a left-half vector is first turned by a quarter turn.
  function automatic longint angle_of(longint y, longint x);
    longint z, ox, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      ox = x;
      if (y >= 0) begin
        x = y; y = -ox; z = HALF_PI;
      end else begin
        x = -y; y = ox; z = -HALF_PI;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_q27[i];
      end else begin
        x -= ys; y += xs; z -= atan_q27[i];
      end
    end
    return z;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [31:0] arc_u(longint dy, longint dx);
    longint ang, st, num, u;
    longint unsigned den, mag, q;
    ang = angle_of(dy, dx);
    st = longint'(signed'(m_st));
    den = 64'(m_sw);
    if (ang < st - ANG_TOL) ang += TWO_PI;
    num = ang - st;
    if (den == 0) begin
      u = (num > 0) ? 64'sd2147483647 : (num < 0) ? -64'sd2147483648 : 0;
    end else begin
      mag = (num < 0) ? -num : num;
      q = ((mag << 24) + den / 2) / den;
      if (q > (64'd1 << 32)) q = 64'd1 << 32;
      u = sat32((num < 0) ? -longint'(q) : longint'(q));
    end
    if (u > -U_TOL && u < U_TOL) u = 0;
    if (u > U_ONE - U_TOL && u < U_ONE + U_TOL) u = U_ONE;
    return u[31:0];
  endfunction

  // Queue the crossings that one accepted point must produce.
  task automatic predict_crossings(logic signed [31:0] px, logic signed [31:0] py);
    longint dy, ady, r, root, xv;
    crossing_t hits[$];
    crossing_t c;
    dy = longint'(py) - longint'(signed'(m_cy));
    ady = (dy < 0) ? -dy : dy;
    r = 64'(m_r);
    if (ady > r) return;
    root = int_sqrt(r * r - ady * ady);
    for (int s = 0; s < 2; s++) begin
      xv = s ? longint'(signed'(m_cx)) + root : longint'(signed'(m_cx)) - root;
      if (xv < longint'(px)) begin
        c.cx = 32'(sat32(xv));
        c.u = arc_u(dy, s ? root : -root);
        c.side = s[0];
        c.fin = 1'b0;
        hits.insert(hits.size(), c);
      end
    end
    foreach (hits[k]) begin
      hits[k].fin = (k == hits.size() - 1);
      crossings_due.insert(crossings_due.size(), hits[k]);
    end
  endtask

  // Driver: a point stays on the bus until its beat is taken.
  always @(negedge clk) begin
    if (!(in_valid && !pt_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_pts.size() > 0) begin
        {point_y, point_x} <= pending_pts.pop_front();
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
    pt_taken = 1'b0;
    // Back-pressure on the crossing side.
    if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) out_stall = $urandom_range(1, 9);
    end
  end

  // Monitor: predict on accepted points, check each crossing beat.
  always @(posedge clk) begin
    crossing_t want;
    if (!rst && in_valid && in_ready) begin
      pt_taken = 1'b1;
      points_sent++;
      predict_crossings(point_x, point_y);
    end
    if (!rst && out_valid && out_ready) begin
      beats_seen++;
      if (crossings_due.size() == 0) begin
        $error("crossing beat with nothing expected: cross_x=%0d", cross_x);
        errors++;
      end else begin
        want = crossings_due.pop_front();
        side_hits[want.side]++;
        if (cross_x !== want.cx) begin
          $error("cross_x: expected %0d, got %0d", want.cx, cross_x);
          errors++;
        end
        if (arc_param !== want.u) begin
          $error("arc_param: expected %0d, got %0d", want.u, arc_param);
          errors++;
        end
        if (right_side !== want.side) begin
          $error("right_side: expected %0d, got %0d", want.side, right_side);
          errors++;
        end
        if (last !== want.fin) begin
          $error("last: expected %0d, got %0d", want.fin, last);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CENTER_X:    m_cx = val;
      REG_CENTER_Y:    m_cy = val;
      REG_RADIUS:      m_r = val[30:0];
      REG_START_ANGLE: m_st = val[29:0];
      REG_SWEEP_ANGLE: m_sw = val[29:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_arc(longint cx, longint cy, longint r, longint st, longint sw);
    write_reg(REG_CENTER_X, cx[31:0]);
    write_reg(REG_CENTER_Y, cy[31:0]);
    write_reg(REG_RADIUS, r[31:0]);
    write_reg(REG_START_ANGLE, st[31:0]);
    write_reg(REG_SWEEP_ANGLE, sw[31:0]);
  endtask

  function automatic logic [31:0] clip32(longint v);
    return 32'(sat32(v));
  endfunction

  function automatic longint rand_span(longint span);
    longint v;
    v = {$urandom, $urandom};
    if (span <= 0) return 0;
    v = (v < 0) ? -v : v;
    return (v % (2 * span + 1)) - span;
  endfunction

  // Mostly points whose ray height lies near the circle, the rest anywhere.
  task automatic queue_random(int n);
    longint r, px, py;
    r = 64'(m_r);
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) begin
        py = longint'(signed'(m_cy)) + rand_span(r + r / 8 + 2);
        px = longint'(signed'(m_cx)) + rand_span(2 * r + 4);
        if ($urandom_range(0, 15) == 0) begin
          py = longint'(signed'(m_cy)) + (($urandom & 1) ? r : -r);
        end
        pending_pts.insert(pending_pts.size(), {clip32(py), clip32(px)});
      end else begin
        pending_pts.insert(pending_pts.size(), {$urandom, $urandom});
      end
    end
  endtask

  task automatic queue_point(longint px, longint py);
    pending_pts.insert(pending_pts.size(), {clip32(py), clip32(px)});
  endtask

  task automatic drain();
    while (pending_pts.size() > 0 || crossings_due.size() > 0 || in_valid)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  initial begin
    longint one;
    one = 64'sd65536;
    for (int i = 0; i < STEPS; i++)
      atan_q27[i] = ((i == 0) ? 4 * atan_recip(5) - atan_recip(239)
                              : atan_recip(64'd1 << i)) + (64'd1 << 32) >> 33;
    m_cx = '0; m_cy = '0; m_r = '0; m_st = '0; m_sw = SWEEP_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: a degenerate circle, so the zero vector gives angle 0.
    queue_point(1, 0);
    queue_point(0, 0);
    queue_point(-1, 0);
    queue_point(5, 1);
    drain();

    // Directed: radius 10 about the origin, full turn.
    set_arc(0, 0, 10 * one, 0, TWO_PI);
    queue_point(20 * one, 0);            // both crossings
    queue_point(0, 0);                   // left crossing only
    queue_point(-10 * one, 0);           // crossing on the point itself, none
    queue_point(20 * one, 10 * one);     // tangent, equal crossings
    queue_point(20 * one, -10 * one);
    queue_point(20 * one, 10 * one + 1); // just beyond the radius
    queue_point(20 * one, 6 * one);
    queue_point(20 * one, -6 * one);
    queue_point(20 * one, -3);           // angle near minus pi
    queue_point(64'sd2147483647, 0);
    queue_point(-64'sd2147483648, 0);
    queue_point(64'sd2147483647, 64'sd2147483647);
    queue_point(64'sd2147483647, -64'sd2147483648);
    queue_random(380);
    drain();

    // Moderate random arc.
    set_arc(rand_span(64'sd1 << 28), rand_span(64'sd1 << 28), $urandom_range(1, 1 << 24),
            rand_span(421657428), $urandom_range(1, 843314856));
    queue_random(250);
    drain();

    // Extremes: far corner, largest radius, smallest sweep.
    set_arc(-64'sd2147483648, 64'sd2147483647, 64'sd2147483647, -421657428, 1);
    queue_random(250);
    drain();

    // Opposite corner, zero sweep.
    set_arc(64'sd2147483647, -64'sd2147483648, 64'sd2147483647, 421657428, 0);
    queue_random(250);
    drain();

    // Raw register values, out of the stated ranges as well.
    set_arc($urandom, $urandom, $urandom, $urandom, $urandom);
    queue_random(250);
    drain();

    // Small circle, half sweep, start past the wrap.
    set_arc(rand_span(1000 * one), rand_span(1000 * one), $urandom_range(1, 64 * one),
            421657428, 421657428);
    queue_random(250);
    drain();

    // Closing stretch with both sides flowing freely.
    set_arc(rand_span(64'sd1 << 30), rand_span(64'sd1 << 30), $urandom_range(0, 1 << 30),
            rand_span(421657428), $urandom_range(1, 843314856));
    calm = 1'b1;
    queue_random(250);
    drain();

    $display("Covered %0d points and %0d crossing beats (%0d left, %0d right)",
             points_sent, beats_seen, side_hits[0], side_hits[1]);
    $display("over eight arc settings, extremes and a zero sweep included.");
    if (errors == 0) begin
      $display("** arc_horizontal_ray_crossings_unit: PASSED **");
    end else begin
      $display("** arc_horizontal_ray_crossings_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** arc_horizontal_ray_crossings_unit: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
sv/ahrc_pkg.sv
sv/ahrc_sqrt_pipe.sv
sv/ahrc_cordic_pipe.sv
sv/ahrc_div_pipe.sv
sv/arc_horizontal_ray_crossings_unit.sv
tb/tb_top.sv
